### hdl/pcbk_pkg.sv
// ----------------------------------------------------------------------------
// pcbk_pkg
// Shared types and constants of the packed 4bpp color-key blitter.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package pcbk_pkg;

    // Frame geometry
    localparam int WORDS_PER_ROW = 40;
    localparam int FRAME_ROWS    = 240;
    localparam int FRAME_WORDS   = WORDS_PER_ROW * FRAME_ROWS;

    // Pixel packing
    localparam int PIX_W     = 4;
    localparam int LANES     = 8;
    localparam int WORD_W    = PIX_W * LANES;
    localparam int WORD_SHIFT = 3;

    // Register field widths
    localparam int WIDTH_W  = 9;
    localparam int HEIGHT_W = 8;
    localparam int DX_W     = 9;
    localparam int DY_W     = 8;
    localparam int KEY_W    = PIX_W;
    localparam int CFG_DATA_W  = 9;
    localparam int CFG_INDEX_W = 3;

    // Counter widths
    localparam int ROW_W = 8;
    localparam int COL_W = 6;
    localparam int WORDS_W = WIDTH_W - WORD_SHIFT + 1;
    localparam int DXW_W   = DX_W - WORD_SHIFT;

    // Index widths: full index wide enough for the largest sum and for the
    // frame size compare
    localparam int FRAME_INDEX_W = 15;
    localparam int ROW_SUM_W     = DY_W + 1;
    localparam int IDX_MAX = ((2 ** DY_W - 1) + (2 ** ROW_W - 1)) * WORDS_PER_ROW
                           + (2 ** DXW_W - 1) + (2 ** COL_W - 1);
    localparam int IDX_BITS   = $clog2(IDX_MAX + 1);
    localparam int FRAME_BITS = $clog2(FRAME_WORDS + 1);
    localparam int IDX_W0 = (IDX_BITS > FRAME_BITS) ? IDX_BITS : FRAME_BITS;
    localparam int IDX_W  = (IDX_W0 > FRAME_INDEX_W) ? IDX_W0 : FRAME_INDEX_W;

    // Register reset values
    localparam logic [WIDTH_W-1:0]  SPRITE_WIDTH_RST  = WIDTH_W'(16);
    localparam logic [HEIGHT_W-1:0] SPRITE_HEIGHT_RST = HEIGHT_W'(32);
    localparam logic [DX_W-1:0]     DEST_X_RST        = '0;
    localparam logic [DY_W-1:0]     DEST_Y_RST        = '0;
    localparam logic [KEY_W-1:0]    KEY_RST           = KEY_W'(1);

    // Register indexes
    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_SPRITE_WIDTH      = 3'd0,
        REG_SPRITE_HEIGHT     = 3'd1,
        REG_DEST_X            = 3'd2,
        REG_DEST_Y            = 3'd3,
        REG_TRANSPARENT_INDEX = 3'd4
    } cfg_reg_t;

    typedef struct packed {
        logic [WIDTH_W-1:0]  sprite_width;
        logic [HEIGHT_W-1:0] sprite_height;
        logic [DX_W-1:0]     dest_x;
        logic [DY_W-1:0]     dest_y;
        logic [KEY_W-1:0]    transparent_index;
    } cfg_t;

    // Destination info for the word at the head of the input
    typedef struct packed {
        logic [FRAME_INDEX_W-1:0] frame_word_index;
        logic                     out_of_frame;
        logic                     last_word;
    } addr_info_t;

    typedef struct packed {
        logic [WORD_W-1:0] merged_word;
        addr_info_t        info;
    } result_t;

endpackage

`default_nettype wire

### hdl/pcbk_lane.sv
// ----------------------------------------------------------------------------
// pcbk_lane
// One nibble lane: pass the sprite pixel unless it matches the color key.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbk_lane
    import pcbk_pkg::*;
(
    input  wire logic [PIX_W-1:0] sprite_pix,
    input  wire logic [PIX_W-1:0] background_pix,
    input  wire logic [KEY_W-1:0] key,
    output logic      [PIX_W-1:0] merged_pix
);

    assign merged_pix = (sprite_pix == key) ? background_pix : sprite_pix;

endmodule

`default_nettype wire

### hdl/pcbk_addr.sv
// ----------------------------------------------------------------------------
// pcbk_addr
// Row/column walk over the sprite and destination word index generation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module pcbk_addr
    import pcbk_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire cfg_t       cfg,
    input  wire logic       advance,
    output addr_info_t      info
);

    logic [ROW_W-1:0]     row_count_reg, row_count_next;
    logic [COL_W-1:0]     word_col_count_reg, word_col_count_next;
    logic [WIDTH_W:0]     width_rounded;
    logic [WORDS_W-1:0]   words;
    logic [COL_W-1:0]     words_m1;
    logic [ROW_W-1:0]     rows_m1;
    logic                 row_end;
    logic                 last;
    logic [ROW_SUM_W-1:0] row_sum;
    logic [IDX_W-1:0]     row_base;
    logic [IDX_W-1:0]     full_idx;

    // Zero width or height counts as one word / one row
    assign width_rounded = {1'b0, cfg.sprite_width} + (WIDTH_W+1)'(LANES - 1);
    assign words         = width_rounded[WIDTH_W:WORD_SHIFT];
    assign words_m1      = (words == '0) ? '0 : COL_W'(words - WORDS_W'(1));
    assign rows_m1       = (cfg.sprite_height == '0) ? '0
                         : ROW_W'(cfg.sprite_height - HEIGHT_W'(1));

    assign row_end = (word_col_count_reg >= words_m1);
    assign last    = row_end && (row_count_reg >= rows_m1);

    assign row_sum  = ROW_SUM_W'(cfg.dest_y) + ROW_SUM_W'(row_count_reg);
    assign row_base = IDX_W'(row_sum) * IDX_W'(WORDS_PER_ROW);
    assign full_idx = row_base + IDX_W'(cfg.dest_x[DX_W-1:WORD_SHIFT])
                    + IDX_W'(word_col_count_reg);

    assign info.frame_word_index = full_idx[FRAME_INDEX_W-1:0];
    assign info.out_of_frame     = (full_idx >= IDX_W'(FRAME_WORDS));
    assign info.last_word        = last;

    always_comb
    begin
        row_count_next      = row_count_reg;
        word_col_count_next = word_col_count_reg;
        if (advance)
        begin
            priority if (last)
            begin
                row_count_next      = '0;
                word_col_count_next = '0;
            end
            else if (row_end)
            begin
                row_count_next      = row_count_reg + ROW_W'(1);
                word_col_count_next = '0;
            end
            else
            begin
                word_col_count_next = word_col_count_reg + COL_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_count_reg      <= '0;
            word_col_count_reg <= '0;
        end
        else
        begin
            row_count_reg      <= row_count_next;
            word_col_count_reg <= word_col_count_next;
        end
    end

endmodule

`default_nettype wire

### hdl/packed_4bpp_color_key_blit.sv
// ----------------------------------------------------------------------------
// packed_4bpp_color_key_blit
// Color-key sprite blitter for a packed 4-bit indexed framebuffer.
// ----------------------------------------------------------------------------
// Each input transaction pairs one sprite word (eight 4-bit pixels, pixel i in
// bits 4i+3..4i) with the framebuffer word at its destination; each result
// transaction carries the merged word, its framebuffer word index, an
// out-of-frame flag and a mark on the sprite's final word. Eight nibble lanes
// run side by side, each taking the background pixel where the sprite pixel
// equals transparent_index, and the merge stage packs them into one word
// together with the index from the row/column walker. Throughput is one
// transaction per clock while in_stall is low; the lane compare/select
// and the single constant multiply of the index path both fit between the
// input and the output register. A one-entry skid buffer behind the output
// register keeps input and output handshakes apart, so in_stall is a plain
// register and rises only once both entries hold results. Sprites arrive row
// by row, ceil(sprite_width/8) words per row; dest_x is truncated to a word
// boundary and indices past the frame are flagged, not clipped. Write the
// configuration registers only while no transaction is in flight. There is no
// clearing pass after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module packed_4bpp_color_key_blit
    import pcbk_pkg::*;
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    // Configuration write port
    input  wire logic                     cfg_we,
    input  wire logic [CFG_INDEX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]    cfg_data,
    // Input channel
    input  wire logic                     in_valid,
    output logic                          in_stall,
    input  wire logic [WORD_W-1:0]        sprite_word,
    input  wire logic [WORD_W-1:0]        background_word,
    // Output channel
    output logic                          out_valid,
    input  wire logic                     out_stall,
    output logic      [WORD_W-1:0]        merged_word,
    output logic      [FRAME_INDEX_W-1:0] frame_word_index,
    output logic                          out_of_frame,
    output logic                          last_word
);

    cfg_t       cfg_reg;
    addr_info_t addr_info;
    logic [WORD_W-1:0] lane_word;
    result_t    result;

    result_t    out_data_reg, out_data_next;
    logic       out_valid_reg, out_valid_next;
    result_t    skid_data_reg, skid_data_next;
    logic       skid_valid_reg, skid_valid_next;

    logic       in_accept;
    logic       out_take;

    // ------------------------------------------------------------------
    // Configuration registers; writes beyond the list are dropped
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.sprite_width      <= SPRITE_WIDTH_RST;
            cfg_reg.sprite_height     <= SPRITE_HEIGHT_RST;
            cfg_reg.dest_x            <= DEST_X_RST;
            cfg_reg.dest_y            <= DEST_Y_RST;
            cfg_reg.transparent_index <= KEY_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_SPRITE_WIDTH:      cfg_reg.sprite_width  <= cfg_data[WIDTH_W-1:0];
                REG_SPRITE_HEIGHT:     cfg_reg.sprite_height <= cfg_data[HEIGHT_W-1:0];
                REG_DEST_X:            cfg_reg.dest_x        <= cfg_data[DX_W-1:0];
                REG_DEST_Y:            cfg_reg.dest_y        <= cfg_data[DY_W-1:0];
                REG_TRANSPARENT_INDEX: cfg_reg.transparent_index <= cfg_data[KEY_W-1:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Handshake: input stalls only while the skid entry is occupied
    // ------------------------------------------------------------------
    assign in_stall  = skid_valid_reg;
    assign in_accept = in_valid && !skid_valid_reg;
    assign out_take  = out_valid_reg && !out_stall;

    // ------------------------------------------------------------------
    // Row/column walker: advance on every accepted transaction
    // ------------------------------------------------------------------
    pcbk_addr u_addr (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg_reg),
        .advance (in_accept),
        .info    (addr_info)
    );

    // ------------------------------------------------------------------
    // Eight color-key lanes
    // ------------------------------------------------------------------
    for (genvar g = 0; g < LANES; g++)
    begin : g_lane
        pcbk_lane u_lane (
            .sprite_pix     (sprite_word[g*PIX_W +: PIX_W]),
            .background_pix (background_word[g*PIX_W +: PIX_W]),
            .key            (cfg_reg.transparent_index),
            .merged_pix     (lane_word[g*PIX_W +: PIX_W])
        );
    end

    // Merge: pack lane outputs with the destination info
    assign result.merged_word = lane_word;
    assign result.info        = addr_info;

    // ------------------------------------------------------------------
    // Output register plus skid entry
    // ------------------------------------------------------------------
    always_comb
    begin
        out_data_next   = out_data_reg;
        out_valid_next  = out_valid_reg;
        skid_data_next  = skid_data_reg;
        skid_valid_next = skid_valid_reg;
        if (skid_valid_reg)
        begin
            // Drain the skid entry into the output register
            if (out_take)
            begin
                out_data_next   = skid_data_reg;
                out_valid_next  = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (in_accept)
        begin
            if (!out_valid_reg || out_take)
            begin
                out_data_next  = result;
                out_valid_next = 1'b1;
            end
            else
            begin
                // Output held: park the new result in the skid entry
                skid_data_next  = result;
                skid_valid_next = 1'b1;
            end
        end
        else if (out_take)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    assign out_valid        = out_valid_reg;
    assign merged_word      = out_data_reg.merged_word;
    assign frame_word_index = out_data_reg.info.frame_word_index;
    assign out_of_frame     = out_data_reg.info.out_of_frame;
    assign last_word        = out_data_reg.info.last_word;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // Skid entry fills only behind a held output
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid entry valid with empty output register");

    // Accepting into an empty output register lands there, not in the skid
    a_accept_direct: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !out_valid_reg) |=> (out_valid_reg && !skid_valid_reg))
        else $error("transaction into empty output went astray");

    // A taken output with a full skid refills the output and frees the skid
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (skid_valid_reg && !out_stall) |=> (out_valid_reg && !skid_valid_reg))
        else $error("skid entry not drained after output taken");

endmodule

`default_nettype wire
